@@ design/assert_macros.svh @@
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/pee_pkg.sv @@
package pee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int AW          = $clog2(STACK_DEPTH);
    localparam int SPW         = $clog2(STACK_DEPTH + 1);
    localparam int DIV_W       = 32 + FRAC_BITS;
    localparam int MIN_LENGTH  = 5;
    localparam int REDUCE_SPAN = 4;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_NINE = 8'd57;
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_TIMES   = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIV0   = 2'd1;
    localparam logic [1:0] ST_SYNTAX = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_GET_B, S_GET_OP, S_GET_A, S_EXEC, S_MUL, S_DIV,
        S_WR, S_DONE, S_FRD, S_FIN
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

@@ design/paren_expression_evaluator_top.sv @@
// Channel   Signals                                   Direction
// input     i_in_valid/o_in_ready, i_character,       in
//           i_last_char
// output    o_out_valid/i_out_ready, o_value,         out
//           o_status
// A final character adds a read of stack entry 0 before the result is formed.
// A ')' reduction does three stack memory reads; * adds a multiply step, and / waits on
// the serial divider (one quotient bit per cycle over 48 bits).
// Reset is synchronous and active low; the stack memory is not cleared.
// A result still waiting on i_out_ready stalls the block at the next final character.
`include "assert_macros.svh"
module paren_expression_evaluator_top
    import pee_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_character,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status
);

    logic [32:0] mem [STACK_DEPTH];
    logic [32:0] r_rd_data;

    t_state r_state, n_state;
    logic [SPW-1:0] r_sp, n_sp;
    logic [7:0] r_cnt_char, n_cnt_char;
    logic [7:0] r_cnt_open, n_cnt_open;
    logic [7:0] r_cnt_close, n_cnt_close;
    logic r_first_open, n_first_open;
    logic [1:0] r_err, n_err;
    logic r_out_valid, n_out_valid;

    logic [7:0] r_ch;
    logic r_last;
    logic signed [31:0] r_a, r_b, n_res, r_res;
    logic r_a_num, r_b_num, r_op_num;
    logic [7:0] r_op;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_out_value;
    logic [1:0] r_out_status;

    logic we, re;
    logic [AW-1:0] waddr, raddr;
    logic [32:0] wdata;
    logic acc, out_free, shape_bad, is_digit, is_close, load_out, div_start, div_done;
    logic signed [31:0] div_quot;
    logic signed [63:0] prod_adj;
    logic [3:0] digit;
    logic [1:0] fin_status;

    assign acc       = i_in_valid && r_state == S_IDLE;
    assign out_free  = !r_out_valid || i_out_ready;
    assign is_close  = i_character == CH_CLOSE;
    assign is_digit  = i_character >= ASCII_ZERO && i_character <= ASCII_NINE;
    assign digit     = 4'(i_character - ASCII_ZERO);
    assign shape_bad = !r_b_num || r_op_num || !r_a_num;
    assign load_out  = r_state == S_FIN && out_free;
    assign prod_adj  = r_prod + (r_prod[63] ? 64'((64'd1 << FRAC_BITS) - 1) : 64'd0);

    pee_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_a),
        .i_den  (r_b),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (r_err == ST_OK && is_close && r_sp >= SPW'(REDUCE_SPAN)) begin
                        n_state = S_GET_B;
                    end else if (i_last_char) begin
                        n_state = S_FRD;
                    end
                end
            end
            S_GET_B:  n_state = S_GET_OP;
            S_GET_OP: n_state = S_GET_A;
            S_GET_A:  n_state = S_EXEC;
            S_EXEC: begin
                if (shape_bad) begin
                    n_state = S_DONE;
                end else if (r_op == CH_PLUS || r_op == CH_MINUS) begin
                    n_state = S_WR;
                end else if (r_op == CH_TIMES) begin
                    n_state = S_MUL;
                end else if (r_op == CH_SLASH && r_b != 32'sd0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: n_state = S_WR;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_WR;
                end
            end
            S_WR, S_DONE: n_state = r_last ? S_FRD : S_IDLE;
            S_FRD: n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Saturated counts and first/last chars, then latched error, then stack shape.
    always_comb begin
        if (r_cnt_char < 8'(MIN_LENGTH) || !r_first_open || r_ch != CH_CLOSE
                || r_cnt_open != r_cnt_close) begin
            fin_status = ST_SYNTAX;
        end else if (r_err != ST_OK) begin
            fin_status = r_err;
        end else if (r_sp != SPW'(1) || !r_rd_data[32]) begin
            fin_status = ST_SYNTAX;
        end else begin
            fin_status = ST_OK;
        end
    end

    // Datapath and memory controls.
    always_comb begin
        n_sp         = r_sp;
        n_cnt_char   = r_cnt_char;
        n_cnt_open   = r_cnt_open;
        n_cnt_close  = r_cnt_close;
        n_first_open = r_first_open;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_res        = r_res;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = r_sp[AW-1:0];
        raddr        = '0;
        wdata        = '0;
        div_start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (r_cnt_char == 8'd0 && i_character == CH_OPEN) begin
                        n_first_open = 1'b1;
                    end
                    if (r_cnt_char != COUNT_MAX) begin
                        n_cnt_char = r_cnt_char + 8'd1;
                    end
                    if (i_character == CH_OPEN && r_cnt_open != COUNT_MAX) begin
                        n_cnt_open = r_cnt_open + 8'd1;
                    end
                    if (is_close && r_cnt_close != COUNT_MAX) begin
                        n_cnt_close = r_cnt_close + 8'd1;
                    end
                    if (r_err == ST_OK) begin
                        if (is_close) begin
                            if (r_sp < SPW'(REDUCE_SPAN)) begin
                                n_err = ST_SYNTAX;
                            end else begin
                                re    = 1'b1;
                                raddr = AW'(r_sp - SPW'(1));
                            end
                        end else if (r_sp >= SPW'(STACK_DEPTH)) begin
                            n_err = ST_SYNTAX;
                        end else begin
                            we    = 1'b1;
                            wdata = is_digit ? {1'b1, 32'(digit) << FRAC_BITS}
                                             : {1'b0, 24'd0, i_character};
                            n_sp  = r_sp + SPW'(1);
                        end
                    end
                end
            end
            S_GET_B: begin
                re    = 1'b1;
                raddr = AW'(r_sp - SPW'(2));
            end
            S_GET_OP: begin
                re    = 1'b1;
                raddr = AW'(r_sp - SPW'(3));
            end
            S_EXEC: begin
                if (shape_bad) begin
                    n_err = ST_SYNTAX;
                end else if (r_op == CH_PLUS) begin
                    n_res = sat32(64'(r_a) + 64'(r_b));
                end else if (r_op == CH_MINUS) begin
                    n_res = sat32(64'(r_a) - 64'(r_b));
                end else if (r_op == CH_TIMES) begin
                    n_res = r_res;
                end else if (r_op == CH_SLASH) begin
                    if (r_b == 32'sd0) begin
                        n_err = ST_DIV0;
                    end else begin
                        div_start = 1'b1;
                    end
                end else begin
                    n_err = ST_SYNTAX;
                end
            end
            S_MUL: n_res = sat32(prod_adj >>> FRAC_BITS);
            S_DIV: begin
                if (div_done) begin
                    n_res = div_quot;
                end
            end
            S_WR: begin
                we    = 1'b1;
                waddr = AW'(r_sp - SPW'(REDUCE_SPAN));
                wdata = {1'b1, r_res};
                n_sp  = r_sp - SPW'(REDUCE_SPAN - 1);
            end
            S_FRD: begin
                re    = 1'b1;
                raddr = '0;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_sp         = '0;
                    n_cnt_char   = '0;
                    n_cnt_open   = '0;
                    n_cnt_close  = '0;
                    n_first_open = 1'b0;
                    n_err        = ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sp         <= '0;
            r_cnt_char   <= '0;
            r_cnt_open   <= '0;
            r_cnt_close  <= '0;
            r_first_open <= 1'b0;
            r_err        <= ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sp         <= n_sp;
            r_cnt_char   <= n_cnt_char;
            r_cnt_open   <= n_cnt_open;
            r_cnt_close  <= n_cnt_close;
            r_first_open <= n_first_open;
            r_err        <= n_err;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (acc) begin
            r_ch   <= i_character;
            r_last <= i_last_char;
        end
        case (r_state)
            S_GET_B: begin
                r_b     <= r_rd_data[31:0];
                r_b_num <= r_rd_data[32];
            end
            S_GET_OP: begin
                r_op     <= r_rd_data[7:0];
                r_op_num <= r_rd_data[32];
            end
            S_GET_A: begin
                r_a     <= r_rd_data[31:0];
                r_a_num <= r_rd_data[32];
            end
            S_EXEC: r_prod <= r_a * r_b;
            default: begin
            end
        endcase
        if (load_out) begin
            r_out_status <= fin_status;
            r_out_value  <= (fin_status == ST_OK) ? r_rd_data[31:0] : 32'sd0;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

    `ASSERT_ALWAYS(a_sp_range, i_clk, i_rst_n, r_sp <= SPW'(STACK_DEPTH))
    `ASSERT_IMPLY(a_div_in_state, i_clk, i_rst_n, div_done, r_state == S_DIV)
    `ASSERT_IMPLY(a_wr_state, i_clk, i_rst_n, we, r_state == S_IDLE || r_state == S_WR)
    `ASSERT_IMPLY(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_FIN)

endmodule

@@ design/pee_div.sv @@
module pee_div
    import pee_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    localparam int CW = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [31:0]      r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [31:0]      r_den;
    logic             r_neg;

    logic [32:0] rem_sh;
    logic        ge;
    logic [31:0] num_mag;
    logic [31:0] den_mag;

    assign num_mag = i_num[31] ? 32'(-i_num) : i_num;
    assign den_mag = i_den[31] ? 32'(-i_den) : i_den;
    assign rem_sh  = {r_rem, r_quo[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle, on magnitudes.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {num_mag, {FRAC_BITS{1'b0}}};
            r_den <= den_mag;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    always_comb begin
        if (!r_neg && r_quo > DIV_W'(32'h7FFF_FFFF)) begin
            o_quot = 32'sh7FFF_FFFF;
        end else if (r_neg && r_quo > DIV_W'(33'h0_8000_0000)) begin
            o_quot = 32'sh8000_0000;
        end else if (r_neg) begin
            o_quot = 32'(-r_quo[31:0]);
        end else begin
            o_quot = r_quo[31:0];
        end
    end

    assign o_done = r_done;

endmodule

@@ verif/expr_checker.sv @@
`timescale 1ns / 100ps
module expr_checker
    import pee_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_character,
    input  logic               i_last_char,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_value,
    input  logic [1:0]         i_status,
    output int                 o_fail_count,
    output int                 o_pending
);
    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_answer;

    logic               tok_is_num [STACK_DEPTH];
    logic signed [31:0] tok_val    [STACK_DEPTH];
    int                 sp;
    int                 n_chars;
    int                 n_open;
    int                 n_close;
    logic               opened_first;
    logic [1:0]         err;
    t_answer            answer_q[$];

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    task automatic clear_expr();
        sp = 0;
        n_chars = 0;
        n_open = 0;
        n_close = 0;
        opened_first = 1'b0;
        err = ST_OK;
    endtask

    task automatic push_tok(input logic is_num, input logic signed [31:0] v);
        if (sp >= STACK_DEPTH) begin
            err = ST_SYNTAX;
        end else begin
            tok_is_num[sp] = is_num;
            tok_val[sp] = v;
            sp++;
        end
    endtask

    task automatic reduce_top();
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [31:0] r;
        if (sp < REDUCE_SPAN || !tok_is_num[sp-1] || tok_is_num[sp-2] || !tok_is_num[sp-3]) begin
            err = ST_SYNTAX;
            return;
        end
        b = tok_val[sp-1];
        a = tok_val[sp-3];
        case (tok_val[sp-2][7:0])
            CH_PLUS:  r = clamp32(a + b);
            CH_MINUS: r = clamp32(a - b);
            CH_TIMES: r = clamp32((a * b) / (64'sd1 <<< FRAC_BITS));
            CH_SLASH: begin
                if (b == 0) begin
                    err = ST_DIV0;
                    return;
                end
                r = clamp32((a * (64'sd1 <<< FRAC_BITS)) / b);
            end
            default: begin
                err = ST_SYNTAX;
                return;
            end
        endcase
        tok_is_num[sp-4] = 1'b1;
        tok_val[sp-4] = r;
        sp -= 3;
    endtask

    task automatic take_char(input logic [7:0] ch, input logic last);
        t_answer ans;
        if (n_chars == 0 && ch == CH_OPEN) opened_first = 1'b1;
        if (n_chars < 255) n_chars++;
        if (ch == CH_OPEN && n_open < 255) n_open++;
        if (ch == CH_CLOSE && n_close < 255) n_close++;
        if (err == ST_OK) begin
            if (ch == CH_CLOSE) begin
                reduce_top();
            end else if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
                push_tok(1'b1, 32'(ch - ASCII_ZERO) <<< FRAC_BITS);
            end else begin
                push_tok(1'b0, 32'(ch));
            end
        end
        if (!last) return;
        ans.value = '0;
        if (n_chars < MIN_LENGTH || !opened_first || ch != CH_CLOSE || n_open != n_close) begin
            ans.status = ST_SYNTAX;
        end else if (err != ST_OK) begin
            ans.status = err;
        end else if (sp != 1 || !tok_is_num[0]) begin
            ans.status = ST_SYNTAX;
        end else begin
            ans.status = ST_OK;
            ans.value = tok_val[0];
        end
        answer_q.push_back(ans);
        clear_expr();
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        clear_expr();
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            clear_expr();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                        i_value, i_status));
                end else begin
                    want = answer_q.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                            i_status, want.status));
                    end
                    if (i_value !== want.value) begin
                        report_mismatch($sformatf("value %0d, expected %0d",
                            i_value, want.value));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_char(i_character, i_last_char);
            end
        end
        o_pending = answer_q.size();
    end
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
    import pee_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM_EXPRS = 115;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         character;
    logic               last_char;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] value;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending;
    logic               quiet;
    int                 idle_cycles;
    logic [7:0]         expr_buf[$];

    paren_expression_evaluator_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_character(character), .i_last_char(last_char),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_value(value), .o_status(status)
    );

    expr_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_character(character), .i_last_char(last_char),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_value(value), .i_status(status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Receiver stalls in bursts of random length.
    always @(posedge clk) begin
        int burst;
        if (!rst_n) begin
            out_ready <= 1'b1;
            burst = 0;
        end else if (burst > 0) begin
            burst--;
            out_ready <= (burst == 0);
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        character <= ch;
        last_char <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_buf();
        for (int k = 0; k < expr_buf.size(); k++) begin
            send_char(expr_buf[k], k == expr_buf.size() - 1);
        end
        expr_buf.delete();
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 4))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_TIMES;
            3: return CH_SLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Appends a random subexpression of at most the given nesting depth; operators may be invalid.
    task automatic build_expr(input int depth);
        if (depth == 0 || $urandom_range(0, 2) == 0) begin
            expr_buf.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
        end else begin
            expr_buf.push_back(CH_OPEN);
            build_expr(depth - 1);
            expr_buf.push_back($urandom_range(0, 15) == 0 ? pick_op()
                               : (CH_PLUS + 8'($urandom_range(0, 4))) );
            build_expr(depth - 1);
            expr_buf.push_back(CH_CLOSE);
        end
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) expr_buf.push_back(s[k]);
        send_buf();
    endtask

    initial begin
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        character = '0;
        last_char = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("(9*9)");
        send_text("(8/0)");
        send_text("(1-9)");
        send_text("(((9*9)*(9*9))*((9*9)*(9*9)))");
        send_text("((((0-9)*(9*9))*((9*9)*(9*9)))-9)");
        send_text("(3/7)");
        send_text("(1+2");
        send_text("1+2)");
        send_text("(1)");
        send_text("(1%2)");
        // A digit before the inner parenthesis leaves only three entries for the last ')'.
        send_text("(5(1+2))");
        for (int k = 0; k < 70; k++) expr_buf.push_back(CH_OPEN);
        expr_buf.push_back(8'hFF);
        for (int k = 0; k < 70; k++) expr_buf.push_back(CH_CLOSE);
        send_buf();
        for (int k = 0; k < 260; k++) expr_buf.push_back(8'($urandom_range(0, 255)));
        send_buf();

        for (int n = 0; n < N_RANDOM_EXPRS; n++) begin
            if (n > N_RANDOM_EXPRS - 20) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 12))
                        expr_buf.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    build_expr(4);
                    expr_buf[$urandom_range(0, expr_buf.size() - 1)] = 8'($urandom_range(0, 255));
                end
                default: build_expr($urandom_range(1, 4));
            endcase
            send_buf();
        end
        in_valid <= 1'b0;
        last_char <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/pee_pkg.sv
design/pee_div.sv
design/paren_expression_evaluator_top.sv
verif/expr_checker.sv
verif/tb_top.sv
